/* design/sip_pkg.sv */
// sip_pkg: shared types and constants for the segment intersection point block.
// No dependencies.
package sip_pkg;

    localparam int MARGIN_W = 16;   // t_margin width, Q0.16 fraction
    localparam int THR_W    = 63;   // det_threshold width, raw Q32.32
    localparam int CFG_W    = 63;   // config write data, widest register

    localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(1);
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(1);

    typedef enum logic [0:0] {
        CFG_DET_THR  = 1'b0,
        CFG_T_MARGIN = 1'b1
    } t_cfg_idx;

    // side data that rides along with the divider lanes
    typedef struct packed {
        logic hit;
        logic neg_x;
        logic neg_y;
    } t_div_side;

endpackage

/* design/sip_if.sv */
// sip_if: valid/ready channel interfaces for segment pairs and intersection results.
// Standalone; widths follow COORD_BITS.
interface sip_in_if #(parameter int COORD_BITS = 32) ();
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [COORD_BITS-1:0] p_base_x;
    logic signed [COORD_BITS-1:0] p_base_y;
    logic signed [COORD_BITS-1:0] p_dir_x;
    logic signed [COORD_BITS-1:0] p_dir_y;
    logic signed [COORD_BITS-1:0] q_base_x;
    logic signed [COORD_BITS-1:0] q_base_y;
    logic signed [COORD_BITS-1:0] q_dir_x;
    logic signed [COORD_BITS-1:0] q_dir_y;

    modport source (output valid, mode, p_base_x, p_base_y, p_dir_x, p_dir_y,
                    q_base_x, q_base_y, q_dir_x, q_dir_y, input ready);
    modport sink   (input valid, mode, p_base_x, p_base_y, p_dir_x, p_dir_y,
                    q_base_x, q_base_y, q_dir_x, q_dir_y, output ready);
endinterface

interface sip_out_if #(parameter int COORD_BITS = 32) ();
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;

    modport source (output valid, hit, cross_x, cross_y, input ready);
    modport sink   (input valid, hit, cross_x, cross_y, output ready);
endinterface

/* design/segment_intersection_point_top.sv */
// segment_intersection_point_top: intersection point of two segments, deep pipeline.
// Uses sip_pkg, sip_in_if / sip_out_if and sip_div.
//
//  channel   dir  handshake       content
//  in_ch     in   valid/ready     mode, p/q base and direction, Q16.16
//  out_ch    out  valid/ready     hit, cross_x, cross_y, Q16.16
//  cfg       in   i_cfg_we only   i_cfg_idx selects det_threshold or t_margin
//
// The pipeline has 8 front stages, COORD_BITS + 5 divider stages and one output register;
// it takes one item per cycle while the output register is not stalled.
// The whole pipeline moves on one enable: it holds only while the output register is
// full and not taken, and ready follows that enable, so nothing is dropped or repeated.
// Synchronous active-low reset clears valid bits and loads the register defaults.
// Config is sampled live and must be written only while the pipeline is empty.
module segment_intersection_point_top #(
    parameter int COORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  sip_pkg::t_cfg_idx               i_cfg_idx,
    input  logic [sip_pkg::CFG_W-1:0]       i_cfg_wdata,
    sip_in_if.sink                          in_ch,
    sip_out_if.source                       out_ch
);

    localparam int CB   = COORD_BITS;
    localparam int MW   = sip_pkg::MARGIN_W;
    localparam int EW   = CB + 1;          // end point
    localparam int DXW  = CB + 2;          // end point difference
    localparam int PW1  = 2 * CB;          // direction cross products
    localparam int PW2  = 2 * CB + 2;      // direction x difference products
    localparam int DW   = 2 * CB + 1;      // signed determinant
    localparam int TW   = 2 * CB + 3;      // signed parameter numerators
    localparam int AW   = 2 * CB;          // determinant magnitude
    localparam int HW   = CB;              // half of the determinant
    localparam int MDW  = MW + AW;         // margin times determinant
    localparam int M5B  = MW + 3;          // five times margin
    localparam int M5W  = M5B + AW;
    localparam int NW   = 3 * CB + 4;      // signed point numerator
    localparam int NMW  = 3 * CB + 3;      // its magnitude
    localparam int QB   = CB + 3;          // quotient bits
    localparam int CW   = 2 * CB + 22;     // parameter test width
    localparam int CMPW = AW + sip_pkg::THR_W;

    // ---------------- configuration registers ----------------
    logic [sip_pkg::THR_W-1:0]    r_det_thr;
    logic [MW-1:0]                r_t_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_thr  <= sip_pkg::THR_RESET;
            r_t_margin <= sip_pkg::MARGIN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sip_pkg::CFG_DET_THR:  r_det_thr  <= i_cfg_wdata[sip_pkg::THR_W-1:0];
                sip_pkg::CFG_T_MARGIN: r_t_margin <= i_cfg_wdata[MW-1:0];
            endcase
        end
    end

    // ---------------- global pipeline enable ----------------
    logic r_out_vld;
    logic w_en;
    logic [8:1] r_vld;

    assign w_en        = !r_out_vld || out_ch.ready;
    assign in_ch.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[7:1], in_ch.valid};
        end
    end

    // ---------------- stage 1: end points and differences ----------------
    logic signed [EW-1:0]  w_pex, w_pey, w_qex, w_qey;
    logic signed [EW-1:0]  r1_pex, r1_pey;
    logic signed [DXW-1:0] r1_dx, r1_dy;
    logic signed [CB-1:0]  r1_pvx, r1_pvy, r1_qvx, r1_qvy;
    logic                  r1_mode;

    always_comb begin
        w_pex = EW'(in_ch.p_base_x) + EW'(in_ch.p_dir_x);
        w_pey = EW'(in_ch.p_base_y) + EW'(in_ch.p_dir_y);
        w_qex = EW'(in_ch.q_base_x) + EW'(in_ch.q_dir_x);
        w_qey = EW'(in_ch.q_base_y) + EW'(in_ch.q_dir_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pex  <= w_pex;
            r1_pey  <= w_pey;
            r1_dx   <= DXW'(w_qex) - DXW'(w_pex);
            r1_dy   <= DXW'(w_qey) - DXW'(w_pey);
            r1_pvx  <= in_ch.p_dir_x;
            r1_pvy  <= in_ch.p_dir_y;
            r1_qvx  <= in_ch.q_dir_x;
            r1_qvy  <= in_ch.q_dir_y;
            r1_mode <= in_ch.mode;
        end
    end

    // ---------------- stage 2: cross products ----------------
    logic signed [PW1-1:0] r2_da, r2_db;
    logic signed [PW2-1:0] r2_ta, r2_tb, r2_sa, r2_sb;
    logic signed [EW-1:0]  r2_pex, r2_pey;
    logic signed [CB-1:0]  r2_pvx, r2_pvy;
    logic                  r2_mode;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_da   <= PW1'(r1_pvy) * PW1'(r1_qvx);
            r2_db   <= PW1'(r1_pvx) * PW1'(r1_qvy);
            r2_ta   <= PW2'(r1_qvy) * PW2'(r1_dx);
            r2_tb   <= PW2'(r1_qvx) * PW2'(r1_dy);
            r2_sa   <= PW2'(r1_pvy) * PW2'(r1_dx);
            r2_sb   <= PW2'(r1_pvx) * PW2'(r1_dy);
            r2_pex  <= r1_pex;
            r2_pey  <= r1_pey;
            r2_pvx  <= r1_pvx;
            r2_pvy  <= r1_pvy;
            r2_mode <= r1_mode;
        end
    end

    // ---------------- stage 3: determinant and numerators ----------------
    logic signed [DW-1:0] r3_det;
    logic signed [TW-1:0] r3_tn, r3_sn;
    logic signed [EW-1:0] r3_pex, r3_pey;
    logic signed [CB-1:0] r3_pvx, r3_pvy;
    logic                 r3_mode;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_det  <= DW'(r2_da) - DW'(r2_db);
            r3_tn   <= TW'(r2_ta) - TW'(r2_tb);
            r3_sn   <= TW'(r2_sa) - TW'(r2_sb);
            r3_pex  <= r2_pex;
            r3_pey  <= r2_pey;
            r3_pvx  <= r2_pvx;
            r3_pvy  <= r2_pvy;
            r3_mode <= r2_mode;
        end
    end

    // ---------------- stage 4: make the determinant positive ----------------
    logic [AW-1:0]        r4_det;
    logic                 r4_det_nz;
    logic signed [TW-1:0] r4_tn, r4_sn;
    logic signed [EW-1:0] r4_pex, r4_pey;
    logic signed [CB-1:0] r4_pvx, r4_pvy;
    logic                 r4_mode;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_det    <= AW'(r3_det[DW-1] ? -r3_det : r3_det);
            r4_det_nz <= (r3_det != '0);
            r4_tn     <= r3_det[DW-1] ? -r3_tn : r3_tn;
            r4_sn     <= r3_det[DW-1] ? -r3_sn : r3_sn;
            r4_pex    <= r3_pex;
            r4_pey    <= r3_pey;
            r4_pvx    <= r3_pvx;
            r4_pvy    <= r3_pvy;
            r4_mode   <= r3_mode;
        end
    end

    // ---------------- stage 5: threshold, margin products, partial products ------
    logic [M5B-1:0]       w_m5;
    logic [MDW-1:0]       r5_md;
    logic [M5W-1:0]       r5_m5d;
    logic                 r5_det_ok;
    logic signed [NW-1:0] r5_pxl, r5_pxh, r5_pyl, r5_pyh;
    logic signed [NW-1:0] r5_txl, r5_txh, r5_tyl, r5_tyh;
    logic [AW-1:0]        r5_det;
    logic signed [TW-1:0] r5_tn, r5_sn;
    logic                 r5_mode;

    assign w_m5 = M5B'({r_t_margin, 2'b00}) + M5B'(r_t_margin);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_det_ok <= r4_det_nz && (CMPW'(r4_det) >= CMPW'(r_det_thr));
            r5_md     <= MDW'(r_t_margin) * MDW'(r4_det);
            r5_m5d    <= M5W'(w_m5) * M5W'(r4_det);
            // end point times determinant, split on the determinant halves
            r5_pxl    <= NW'(r4_pex) * NW'($signed({1'b0, r4_det[HW-1:0]}));
            r5_pxh    <= NW'(r4_pex) * NW'($signed({1'b0, r4_det[AW-1:HW]}));
            r5_pyl    <= NW'(r4_pey) * NW'($signed({1'b0, r4_det[HW-1:0]}));
            r5_pyh    <= NW'(r4_pey) * NW'($signed({1'b0, r4_det[AW-1:HW]}));
            // t numerator times direction, split on the numerator
            r5_txl    <= NW'(r4_pvx) * NW'($signed({1'b0, r4_tn[HW-1:0]}));
            r5_txh    <= NW'(r4_pvx) * NW'($signed(r4_tn[TW-1:HW]));
            r5_tyl    <= NW'(r4_pvy) * NW'($signed({1'b0, r4_tn[HW-1:0]}));
            r5_tyh    <= NW'(r4_pvy) * NW'($signed(r4_tn[TW-1:HW]));
            r5_det    <= r4_det;
            r5_tn     <= r4_tn;
            r5_sn     <= r4_sn;
            r5_mode   <= r4_mode;
        end
    end

    // ---------------- stage 6: recombine partial products ----------------
    // lower bound is -sel, upper bound is det*2^16 + sel
    logic signed [NW-1:0] r6_pnx, r6_pny, r6_tnx, r6_tny;
    logic signed [CW-1:0] r6_sel;
    logic [AW-1:0]        r6_det;
    logic signed [TW-1:0] r6_tn, r6_sn;
    logic                 r6_det_ok;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_pnx    <= (r5_pxh <<< HW) + r5_pxl;
            r6_pny    <= (r5_pyh <<< HW) + r5_pyl;
            r6_tnx    <= (r5_txh <<< HW) + r5_txl;
            r6_tny    <= (r5_tyh <<< HW) + r5_tyl;
            r6_sel    <= r5_mode ? -$signed(CW'(r5_m5d)) : $signed(CW'(r5_md));
            r6_det    <= r5_det;
            r6_tn     <= r5_tn;
            r6_sn     <= r5_sn;
            r6_det_ok <= r5_det_ok;
        end
    end

    // ---------------- stage 7: numerators and bound offsets ----------------
    logic signed [CW-1:0] w_sct, w_scs;
    logic signed [NW-1:0] r7_nx, r7_ny;
    logic signed [CW-1:0] r7_ut, r7_wt, r7_us, r7_ws, r7_d16;
    logic [AW-1:0]        r7_det;
    logic                 r7_det_ok;

    assign w_sct = CW'(r6_tn) <<< MW;
    assign w_scs = CW'(r6_sn) <<< MW;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_nx     <= r6_pnx - r6_tnx;
            r7_ny     <= r6_pny - r6_tny;
            r7_ut     <= w_sct + r6_sel;
            r7_wt     <= w_sct - r6_sel;
            r7_us     <= w_scs + r6_sel;
            r7_ws     <= w_scs - r6_sel;
            r7_d16    <= $signed(CW'(r6_det)) <<< MW;
            r7_det    <= r6_det;
            r7_det_ok <= r6_det_ok;
        end
    end

    // ---------------- stage 8: parameter tests and magnitudes ----------------
    logic                 w_pass;
    logic [NMW-1:0]       r8_mx, r8_my;
    logic [AW-1:0]        r8_det;
    sip_pkg::t_div_side   r8_side;

    assign w_pass = !r7_ut[CW-1] && (r7_wt <= r7_d16) &&
                    !r7_us[CW-1] && (r7_ws <= r7_d16);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_mx         <= NMW'(r7_nx[NW-1] ? -r7_nx : r7_nx);
            r8_my         <= NMW'(r7_ny[NW-1] ? -r7_ny : r7_ny);
            r8_det        <= r7_det;
            r8_side.hit   <= r7_det_ok && w_pass;
            r8_side.neg_x <= r7_nx[NW-1];
            r8_side.neg_y <= r7_ny[NW-1];
        end
    end

    // ---------------- divider ----------------
    logic                 w_dv_vld;
    logic [QB:0]          w_qx, w_qy;
    sip_pkg::t_div_side   w_dv_side;

    sip_div #(
        .NUM_W (NMW),
        .DEN_W (AW),
        .QUO_W (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[8]),
        .i_num_x (r8_mx),
        .i_num_y (r8_my),
        .i_den   (r8_det),
        .i_side  (r8_side),
        .o_vld   (w_dv_vld),
        .o_quo_x (w_qx),
        .o_quo_y (w_qy),
        .o_side  (w_dv_side)
    );

    // ---------------- output: sign, saturate, clear on miss ----------------
    logic signed [QB+1:0] w_vx, w_vy;
    logic [CB-1:0]        w_cx, w_cy;
    logic                 r_out_hit;
    logic [CB-1:0]        r_out_x, r_out_y;

    always_comb begin
        w_vx = w_dv_side.neg_x ? -$signed((QB+2)'(w_qx)) : $signed((QB+2)'(w_qx));
        w_vy = w_dv_side.neg_y ? -$signed((QB+2)'(w_qy)) : $signed((QB+2)'(w_qy));
        // in range when the bits above the sign all copy it
        if (w_vx[QB+1:CB-1] == '0 || w_vx[QB+1:CB-1] == '1) begin
            w_cx = w_vx[CB-1:0];
        end else begin
            w_cx = w_vx[QB+1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end
        if (w_vy[QB+1:CB-1] == '0 || w_vy[QB+1:CB-1] == '1) begin
            w_cy = w_vy[CB-1:0];
        end else begin
            w_cy = w_vy[QB+1] ? {1'b1, {(CB-1){1'b0}}} : {1'b0, {(CB-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hit <= w_dv_side.hit;
            r_out_x   <= w_dv_side.hit ? w_cx : '0;
            r_out_y   <= w_dv_side.hit ? w_cy : '0;
        end
    end

    assign out_ch.valid   = r_out_vld;
    assign out_ch.hit     = r_out_hit;
    assign out_ch.cross_x = r_out_x;
    assign out_ch.cross_y = r_out_y;

    // ---------------- assertions ----------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.hit |-> out_ch.cross_x == '0 && out_ch.cross_y == '0)
        else $error("miss with nonzero point");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |-> !in_ch.ready)
        else $error("intake open while output stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.valid && in_ch.ready |=> r_vld[1])
        else $error("accepted item not in stage 1");

endmodule

/* design/sip_div.sv */
// sip_div: pipelined restoring divider, two numerator lanes over a shared divisor,
// one quotient bit per stage, round half away from zero. Uses sip_pkg.
module sip_div #(
    parameter int NUM_W = 99,
    parameter int DEN_W = 64,
    parameter int QUO_W = 35
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [NUM_W-1:0]      i_num_x,
    input  logic [NUM_W-1:0]      i_num_y,
    input  logic [DEN_W-1:0]      i_den,
    input  sip_pkg::t_div_side    i_side,
    output logic                  o_vld,
    output logic [QUO_W:0]        o_quo_x,
    output logic [QUO_W:0]        o_quo_y,
    output sip_pkg::t_div_side    o_side
);

    // stage k holds the partial remainder after k quotient bits
    logic                 r_vld  [QUO_W+1];
    logic [DEN_W-1:0]     r_rx   [QUO_W+1];
    logic [DEN_W-1:0]     r_ry   [QUO_W+1];
    logic [QUO_W-1:0]     r_nx   [QUO_W+1];
    logic [QUO_W-1:0]     r_ny   [QUO_W+1];
    logic [QUO_W-1:0]     r_qx   [QUO_W+1];
    logic [QUO_W-1:0]     r_qy   [QUO_W+1];
    logic [DEN_W-1:0]     r_den  [QUO_W+1];
    sip_pkg::t_div_side   r_side [QUO_W+1];

    logic                 r_o_vld;
    logic [QUO_W:0]       r_o_qx;
    logic [QUO_W:0]       r_o_qy;
    sip_pkg::t_div_side   r_o_side;
    logic                 w_rnd_x;
    logic                 w_rnd_y;

    // load: the high part of the numerator is below the divisor for every hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0]   <= DEN_W'(i_num_x >> QUO_W);
            r_ry[0]   <= DEN_W'(i_num_y >> QUO_W);
            r_nx[0]   <= i_num_x[QUO_W-1:0];
            r_ny[0]   <= i_num_y[QUO_W-1:0];
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [DEN_W:0] w_tx;
        logic [DEN_W:0] w_ty;
        logic           w_gex;
        logic           w_gey;

        always_comb begin
            w_tx  = {r_rx[k], r_nx[k][QUO_W-1-k]};
            w_ty  = {r_ry[k], r_ny[k][QUO_W-1-k]};
            w_gex = (w_tx >= {1'b0, r_den[k]});
            w_gey = (w_ty >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rx[k+1]   <= w_gex ? DEN_W'(w_tx - {1'b0, r_den[k]}) : DEN_W'(w_tx);
                r_ry[k+1]   <= w_gey ? DEN_W'(w_ty - {1'b0, r_den[k]}) : DEN_W'(w_ty);
                r_qx[k+1]   <= {r_qx[k][QUO_W-2:0], w_gex};
                r_qy[k+1]   <= {r_qy[k][QUO_W-2:0], w_gey};
                r_nx[k+1]   <= r_nx[k];
                r_ny[k+1]   <= r_ny[k];
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // round up when twice the remainder reaches the divisor
    always_comb begin
        w_rnd_x = ({r_rx[QUO_W], 1'b0} >= {1'b0, r_den[QUO_W]});
        w_rnd_y = ({r_ry[QUO_W], 1'b0} >= {1'b0, r_den[QUO_W]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_en) begin
            r_o_vld <= r_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_o_qx   <= (QUO_W+1)'(r_qx[QUO_W]) + (QUO_W+1)'(w_rnd_x);
            r_o_qy   <= (QUO_W+1)'(r_qy[QUO_W]) + (QUO_W+1)'(w_rnd_y);
            r_o_side <= r_side[QUO_W];
        end
    end

    assign o_vld   = r_o_vld;
    assign o_quo_x = r_o_qx;
    assign o_quo_y = r_o_qy;
    assign o_side  = r_o_side;

endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for segment_intersection_point_top.
// Depends on sip_pkg, sip_in_if / sip_out_if and the top level from design/.
`timescale 1ns / 100ps

module testbench;

    localparam int    CW          = 32;
    localparam int    PIPE_DEPTH  = CW + 14;
    localparam int    NUM_PHASES  = 6;
    localparam int    PHASE_ITEMS = 185;
    localparam int    STALL_LEN   = 300;
    localparam int    CYCLE_LIMIT = 400000;
    localparam real   HALF_PERIOD = 5.0;

    typedef logic signed [255:0] t_wide;

    typedef struct packed {
        logic          mode;
        logic [CW-1:0] pbx, pby, pvx, pvy, qbx, qby, qvx, qvy;
    } t_pair;

    typedef struct packed {
        logic          hit;
        logic [CW-1:0] cx, cy;
    } t_cross;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    sip_pkg::t_cfg_idx i_cfg_idx = sip_pkg::CFG_DET_THR;
    logic [sip_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    sip_in_if  #(.COORD_BITS(CW)) in_ch ();
    sip_out_if #(.COORD_BITS(CW)) out_ch ();

    segment_intersection_point_top #(.COORD_BITS(CW)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch.sink),
        .out_ch      (out_ch.source)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // bench copy of the config registers
    logic [sip_pkg::THR_W-1:0]    thr_reg    = sip_pkg::THR_RESET;
    logic [sip_pkg::MARGIN_W-1:0] margin_reg = sip_pkg::MARGIN_RESET;

    t_pair  pending_pairs[$];
    t_cross expected_crossings[$];
    t_pair  cur_pair;
    int     send_idle_pct = 17;
    int     recv_idle_pct = 63;
    bit     send_hold = 1'b0;
    bit     rx_stall_go = 1'b0;
    int     mismatch_cnt = 0;
    int     cycle_cnt = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic t_wide div_round(t_wide n, t_wide d);
        t_wide a, q, r;
        a = (n < 0) ? -n : n;
        q = a / d;
        r = a % d;
        if (2 * r >= d) q = q + 1;
        return (n < 0) ? -q : q;
    endfunction

    function automatic logic [CW-1:0] clamp_coord(t_wide v);
        if (v > t_wide'(64'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
        if (v < -t_wide'(64'sh8000_0000)) return 32'h8000_0000;
        return v[CW-1:0];
    endfunction

    function automatic bit param_in_window(t_wide num, t_wide det, t_wide lo, t_wide hi);
        t_wide sc;
        sc = num * t_wide'(65536);
        return (sc >= lo * det) && (sc <= hi * det);
    endfunction

    function automatic t_cross predict_crossing(t_pair p);
        t_wide pbx, pby, pvx, pvy, qbx, qby, qvx, qvy;
        t_wide pex, pey, dx, dy, det, tn, sn, lo, hi, m, adet;
        t_cross r;
        r = '0;
        pbx = t_wide'($signed(p.pbx)); pby = t_wide'($signed(p.pby));
        pvx = t_wide'($signed(p.pvx)); pvy = t_wide'($signed(p.pvy));
        qbx = t_wide'($signed(p.qbx)); qby = t_wide'($signed(p.qby));
        qvx = t_wide'($signed(p.qvx)); qvy = t_wide'($signed(p.qvy));
        pex = pbx + pvx;
        pey = pby + pvy;
        dx  = qbx + qvx - pex;
        dy  = qby + qvy - pey;
        det = pvy * qvx - pvx * qvy;
        tn  = qvy * dx - qvx * dy;
        sn  = pvy * dx - pvx * dy;
        adet = (det < 0) ? -det : det;
        // zero or near-parallel determinant: no hit
        if (det == 0 || adet < t_wide'({1'b0, thr_reg})) return r;
        if (det < 0) begin
            det = -det; tn = -tn; sn = -sn;
        end
        m = t_wide'({1'b0, margin_reg});
        if (p.mode) begin
            lo = 5 * m;
            hi = t_wide'(65536) - 5 * m;   // empty window once 10*eps > 1
        end else begin
            lo = -m;
            hi = t_wide'(65536) + m;
        end
        if (!param_in_window(tn, det, lo, hi) || !param_in_window(sn, det, lo, hi))
            return r;
        r.hit = 1'b1;
        r.cx  = clamp_coord(div_round(pex * det - tn * pvx, det));
        r.cy  = clamp_coord(div_round(pey * det - tn * pvy, det));
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Driver: one NBA per signal per edge; prediction at acceptance
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_crossings.push_back(predict_crossing(cur_pair));
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_pairs.size() > 0 && !send_hold &&
                    $urandom_range(99) >= send_idle_pct) begin
                    cur_pair = pending_pairs.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.mode     <= cur_pair.mode;
                    in_ch.p_base_x <= cur_pair.pbx;
                    in_ch.p_base_y <= cur_pair.pby;
                    in_ch.p_dir_x  <= cur_pair.pvx;
                    in_ch.p_dir_y  <= cur_pair.pvy;
                    in_ch.q_base_x <= cur_pair.qbx;
                    in_ch.q_base_y <= cur_pair.qby;
                    in_ch.q_dir_x  <= cur_pair.qvx;
                    in_ch.q_dir_y  <= cur_pair.qvy;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        {in_ch.p_base_x, in_ch.p_base_y, in_ch.p_dir_x, in_ch.p_dir_y} = '0;
        {in_ch.q_base_x, in_ch.q_base_y, in_ch.q_dir_x, in_ch.q_dir_y} = '0;
        out_ch.ready = 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor and checker
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_cnt);
        mismatch_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_cross want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_crossings.size() == 0) begin
                    report_mismatch("unexpected item", {31'b0, out_ch.hit}, '0);
                end else begin
                    want = expected_crossings.pop_front();
                    if (out_ch.hit !== want.hit)
                        report_mismatch("hit", {31'b0, out_ch.hit}, {31'b0, want.hit});
                    if (out_ch.cross_x !== want.cx)
                        report_mismatch("cross_x", out_ch.cross_x, want.cx);
                    if (out_ch.cross_y !== want.cy)
                        report_mismatch("cross_y", out_ch.cross_y, want.cy);
                end
            end
            out_ch.ready <= !rx_stall_go && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // long receiver hold-off, counted here so the pipe backs up into the input
    always begin
        wait (rx_stall_go);
        repeat (STALL_LEN) @(posedge i_clk);
        rx_stall_go = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[segment_intersection_point_top] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    // each write sets and clears the enable on edges of its own, so back-to-back calls never
    // schedule two updates of the write enable in one time step
    task automatic write_reg(sip_pkg::t_cfg_idx idx, logic [sip_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == sip_pkg::CFG_DET_THR) thr_reg = val[sip_pkg::THR_W-1:0];
        else                             margin_reg = val[sip_pkg::MARGIN_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_pairs.size() > 0 || in_ch.valid || expected_crossings.size() > 0)
            @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
    endtask

    function automatic t_pair build_pair(bit mode, int pbx, int pby, int pvx, int pvy,
                                         int qbx, int qby, int qvx, int qvy);
        t_pair p;
        p.mode = mode;
        p.pbx = pbx; p.pby = pby; p.pvx = pvx; p.pvy = pvy;
        p.qbx = qbx; p.qby = qby; p.qvx = qvx; p.qvy = qvy;
        return p;
    endfunction

    // segment through point (cx, cy); scale 16 puts it at the far end, larger
    // scales pull it toward the interior
    function automatic void seg_through(longint cx, longint cy,
                                        output logic [CW-1:0] bx, by, vx, vy);
        longint ox, oy, a;
        ox = longint'($urandom_range(1 << 21)) - (1 << 20);
        oy = longint'($urandom_range(1 << 21)) - (1 << 20);
        a  = longint'($urandom_range(40, 14));
        bx = CW'(cx + ox);
        by = CW'(cy + oy);
        vx = CW'((-ox * a) / 16);
        vy = CW'((-oy * a) / 16);
    endfunction

    function automatic t_pair random_pair();
        t_pair p;
        int kind;
        longint cx, cy;
        kind = $urandom_range(99);
        p.mode = 1'($urandom_range(1));
        if (kind < 60) begin
            cx = longint'($urandom_range(1 << 25)) - (1 << 24);
            cy = longint'($urandom_range(1 << 25)) - (1 << 24);
            seg_through(cx, cy, p.pbx, p.pby, p.pvx, p.pvy);
            seg_through(cx, cy, p.qbx, p.qby, p.qvx, p.qvy);
        end else if (kind < 75) begin
            {p.pbx, p.pby, p.pvx, p.pvy} = {$urandom, $urandom, $urandom, $urandom}
                                           & {4{32'h0007_FFFF}};
            {p.qbx, p.qby, p.qvx, p.qvy} = {$urandom, $urandom, $urandom, $urandom}
                                           & {4{32'h0007_FFFF}};
        end else if (kind < 92) begin
            {p.pbx, p.pby, p.pvx, p.pvy} = {$urandom, $urandom, $urandom, $urandom};
            {p.qbx, p.qby, p.qvx, p.qvy} = {$urandom, $urandom, $urandom, $urandom};
        end else begin
            // parallel or collinear noise
            {p.pbx, p.pby, p.qbx, p.qby} = {$urandom, $urandom, $urandom, $urandom};
            p.pvx = $urandom_range(1 << 20);
            p.pvy = $urandom_range(1 << 20);
            p.qvx = -p.pvx;
            p.qvy = -p.pvy;
        end
        return p;
    endfunction

    initial begin
        int mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            // idle regimes: sender-light, then receiver-light, then none
            if (ph < 2) begin
                send_idle_pct = 17; recv_idle_pct = 63;
            end else if (ph < 4) begin
                send_idle_pct = 63; recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            case (ph)
                0: ;    // reset defaults
                1: begin
                    write_reg(sip_pkg::CFG_DET_THR, 63'd0);
                    write_reg(sip_pkg::CFG_T_MARGIN, 63'd0);
                end
                2: begin
                    write_reg(sip_pkg::CFG_DET_THR, 63'd1 << 20);
                    write_reg(sip_pkg::CFG_T_MARGIN, 63'd6554);  // interior window empty
                end
                3: begin
                    write_reg(sip_pkg::CFG_DET_THR, {sip_pkg::CFG_W{1'b1}});
                    write_reg(sip_pkg::CFG_T_MARGIN, 63'hFFFF);
                end
                4: begin
                    write_reg(sip_pkg::CFG_DET_THR, 63'd1 << $urandom_range(40));
                    write_reg(sip_pkg::CFG_T_MARGIN,
                              sip_pkg::CFG_W'($urandom_range(3000)));
                end
                default: begin
                    write_reg(sip_pkg::CFG_DET_THR, 63'd1);
                    write_reg(sip_pkg::CFG_T_MARGIN, 63'd3276);  // interior window open, about half wide
                end
            endcase

            if (ph == 0) begin
                for (int md = 0; md < 2; md++) begin
                    // degenerate all-zero pair
                    pending_pairs.push_back(build_pair(md, 0, 0, 0, 0, 0, 0, 0, 0));
                    // plain X crossing
                    pending_pairs.push_back(build_pair(md, 0, 0, 2 << 16, 2 << 16,
                                            0, 2 << 16, 2 << 16, -(2 << 16)));
                    // touching at an end point
                    pending_pairs.push_back(build_pair(md, 0, 0, 1 << 16, 0,
                                            1 << 16, -(1 << 16), 0, 2 << 16));
                    // parallel
                    pending_pairs.push_back(build_pair(md, 0, 0, 1 << 16, 1 << 16,
                                            0, 1 << 16, 2 << 16, 2 << 16));
                    // field extremes
                    pending_pairs.push_back(build_pair(md, mx, mx, mx, mx, mx, mx, mx, mx));
                    pending_pairs.push_back(build_pair(md, mn, mn, mn, mn, mn, mn, mn, mn));
                    pending_pairs.push_back(build_pair(md, mx, mn, mx, mn, mn, mx, mn, mx));
                    // far crossing, saturates
                    pending_pairs.push_back(build_pair(md, mx, 0, mx, 1 << 16,
                                            mx, 1 << 16, mx, -(1 << 16)));
                end
            end

            if (ph == 2) rx_stall_go = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == PHASE_ITEMS / 2) begin
                    // sender pause until the pipe is fully drained
                    while (pending_pairs.size() > 0 || in_ch.valid ||
                           expected_crossings.size() > 0)
                        @(posedge i_clk);
                end
                pending_pairs.push_back(random_pair());
            end
        end

        wait_drained();
        if (mismatch_cnt == 0)
            $display("[segment_intersection_point_top] OK");
        else
            $display("[segment_intersection_point_top] ERROR");
        $finish;
    end

endmodule

/* files.f */
design/sip_pkg.sv
design/sip_if.sv
design/sip_div.sv
design/segment_intersection_point_top.sv
verif/testbench.sv
